### src/fragment_reassembly_ack_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fragment reassembly ack tracker
// Concurrent checks sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_ACK_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_ACK_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define FRAT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FRAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/frat_pkg.sv
// ----------------------------------------------------------------------------
// frat_pkg
// Types and constants of the fragment reassembly ack tracker.
// ----------------------------------------------------------------------------
package frat_pkg;

  localparam int unsigned MaxFragments = 32;
  localparam int unsigned IdW          = 32;
  localparam int unsigned IdxW         = 5;
  localparam int unsigned TotW         = 6;
  localparam int unsigned IntervalW    = 8;
  localparam int unsigned ActW         = 3;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = $clog2(QDepth);
  localparam int unsigned QCntW        = $clog2(QDepth + 1);

  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(3);

  typedef enum logic [ActW-1:0] {
    ACT_QUIET    = 3'd0,
    ACT_PARTIAL  = 3'd1,
    ACT_COMPLETE = 3'd2,
    ACT_RESEND   = 3'd3,
    ACT_FLUSH    = 3'd4
  } action_e;

  typedef logic [MaxFragments-1:0] frag_map_t;

  typedef struct packed {
    action_e          action;
    logic [IdW-1:0]   packet_id;
    frag_map_t        map;
    logic [IdxW-1:0]  index;
    logic             last;
  } result_t;

endpackage

### src/fragment_reassembly_ack_tracker.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_ack_tracker
// Tracks reassembly of one packet in a fragment bitmap and emits ack results.
// ----------------------------------------------------------------------------
// A header's results are written into the result queue when it is accepted.
// Throughput: one header per cycle while out_ready_i is high and each header
//   draws one result; a header that flushes an open packet draws two, and the
//   pace is set by the one result popped per cycle from the four-entry queue.
// Reset: asynchronous, active low; clears the tracking state, empties the
//   result queue and loads the ack interval with 3.
// ----------------------------------------------------------------------------
`include "fragment_reassembly_ack_tracker_assert.svh"

module fragment_reassembly_ack_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [frat_pkg::IntervalW-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [frat_pkg::IdW-1:0]            packet_id_i,
  input  logic [frat_pkg::IdxW-1:0]           fragment_index_i,
  input  logic [frat_pkg::TotW-1:0]           fragment_total_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [frat_pkg::ActW-1:0]           action_o,
  output logic [frat_pkg::IdW-1:0]            ack_packet_id_o,
  output logic [frat_pkg::MaxFragments-1:0]   ack_map_o,
  output logic [frat_pkg::IdxW-1:0]           ack_index_o,
  output logic                                last_o
);

  // tracking state
  logic [frat_pkg::IntervalW-1:0] interval_q;
  logic                           open_q, open_d;
  logic [frat_pkg::IdW-1:0]       open_id_q, open_id_d;
  logic [frat_pkg::IdW-1:0]       done_id_q, done_id_d;
  logic [frat_pkg::TotW-1:0]      exp_tot_q, exp_tot_d;
  logic [frat_pkg::TotW-1:0]      rcv_tot_q, rcv_tot_d;
  frat_pkg::frag_map_t            map_q, map_d;
  logic [frat_pkg::IntervalW-1:0] spacing_q, spacing_d;

  // result queue
  frat_pkg::result_t              queue_q [frat_pkg::QDepth];
  logic [frat_pkg::QPtrW-1:0]     rd_ptr_q, wr_ptr_q;
  logic [frat_pkg::QCntW-1:0]     count_q;

  logic                           accept, pop;
  logic                           flush, open_eff, resend;
  frat_pkg::result_t              flush_res, main_res;
  frat_pkg::frag_map_t            base_map, bit_mask, new_map;
  logic [frat_pkg::TotW-1:0]      base_tot, base_exp, new_tot;
  logic [frat_pkg::IntervalW-1:0] spacing_inc;
  frat_pkg::result_t              head;

  assign in_ready_o  = (count_q <= frat_pkg::QCntW'(frat_pkg::QDepth - 2));
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    flush    = open_q && (open_id_q != packet_id_i);
    open_eff = open_q && !flush;
    resend   = !open_eff && (packet_id_i != '0) && (packet_id_i == done_id_q);

    flush_res.action    = frat_pkg::ACT_FLUSH;
    flush_res.packet_id = open_id_q;
    flush_res.map       = map_q;
    flush_res.index     = '0;
    flush_res.last      = 1'b0;

    base_map    = open_eff ? map_q : '0;
    base_tot    = open_eff ? rcv_tot_q : '0;
    base_exp    = open_eff ? exp_tot_q : fragment_total_i;
    bit_mask    = frat_pkg::frag_map_t'(1) << fragment_index_i;
    new_map     = base_map | bit_mask;
    new_tot     = base_tot + frat_pkg::TotW'(1);
    spacing_inc = spacing_q + frat_pkg::IntervalW'(1);

    open_d    = open_eff;
    open_id_d = open_id_q;
    done_id_d = done_id_q;
    exp_tot_d = exp_tot_q;
    rcv_tot_d = rcv_tot_q;
    map_d     = map_q;
    spacing_d = spacing_q;

    main_res.action    = frat_pkg::ACT_QUIET;
    main_res.packet_id = packet_id_i;
    main_res.map       = new_map;
    main_res.index     = fragment_index_i;
    main_res.last      = 1'b1;

    if (resend) begin
      main_res.action = frat_pkg::ACT_RESEND;
      main_res.map    = '0;
    end else begin
      open_d    = 1'b1;
      open_id_d = packet_id_i;
      done_id_d = open_eff ? done_id_q : packet_id_i;
      exp_tot_d = base_exp;
      priority if (base_tot == '0) begin
        // first fragment of the packet
        map_d     = new_map;
        rcv_tot_d = frat_pkg::TotW'(1);
        if (fragment_total_i == frat_pkg::TotW'(1)) begin
          main_res.action = frat_pkg::ACT_COMPLETE;
          open_d          = 1'b0;
        end
      end else if ((base_map & bit_mask) != '0) begin
        main_res.action = frat_pkg::ACT_PARTIAL;
      end else begin
        map_d     = new_map;
        rcv_tot_d = new_tot;
        if (new_tot == base_exp) begin
          main_res.action = frat_pkg::ACT_COMPLETE;
          open_d          = 1'b0;
        end else if (spacing_inc == interval_q) begin
          main_res.action = frat_pkg::ACT_PARTIAL;
          spacing_d       = '0;
        end else begin
          spacing_d = spacing_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= frat_pkg::IntervalReset;
      open_q     <= 1'b0;
      open_id_q  <= '0;
      done_id_q  <= '0;
      exp_tot_q  <= '0;
      rcv_tot_q  <= '0;
      map_q      <= '0;
      spacing_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (accept) begin
        open_q    <= open_d;
        open_id_q <= open_id_d;
        done_id_q <= done_id_d;
        exp_tot_q <= exp_tot_d;
        rcv_tot_q <= rcv_tot_d;
        map_q     <= map_d;
        spacing_q <= spacing_d;
      end
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + frat_pkg::QPtrW'(1);
      end
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + (flush ? frat_pkg::QPtrW'(2) : frat_pkg::QPtrW'(1));
      end
      count_q <= count_q
               + (accept ? (flush ? frat_pkg::QCntW'(2) : frat_pkg::QCntW'(1)) : '0)
               - (pop ? frat_pkg::QCntW'(1) : '0);
    end
  end

  // queue storage: the flush result goes ahead of the fragment's own result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (flush) begin
        queue_q[wr_ptr_q]                           <= flush_res;
        queue_q[wr_ptr_q + frat_pkg::QPtrW'(1)]     <= main_res;
      end else begin
        queue_q[wr_ptr_q] <= main_res;
      end
    end
  end

  assign head            = queue_q[rd_ptr_q];
  assign action_o        = head.action;
  assign ack_packet_id_o = head.packet_id;
  assign ack_map_o       = head.map;
  assign ack_index_o     = head.index;
  assign last_o          = head.last;

  `FRAT_ASSERT_IMPLY(a_queue_room, in_ready_o,
    count_q <= frat_pkg::QCntW'(frat_pkg::QDepth - 2),
    "accepting without room for two results")
  `FRAT_ASSERT_NEXT(a_result_follows, accept, out_valid_o,
    "accepted header produced no result")
  `FRAT_ASSERT_IMPLY(a_only_flush_not_last, out_valid_o && !last_o,
    action_o == frat_pkg::ACT_FLUSH, "non-final result is not a flush")
  `FRAT_ASSERT_IMPLY(a_open_has_fragment, open_q, rcv_tot_q != '0,
    "open packet with no fragment received")

endmodule
